@@ hdl/double_ended_queue_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define DEQ_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define DEQ_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ hdl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants and types of the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 9;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_READ       = 3'd4,
        ACT_CLEAR      = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

endpackage

`default_nettype wire

@@ hdl/deq_in_if.sv @@
// ----------------------------------------------------------------------------
// deq_in_if
// Command channel: one queue action per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_in_if;

    logic                                 valid;
    logic                                 ready;
    logic [deq_pkg::ACTION_W-1:0]         action;
    logic signed [deq_pkg::DATA_W-1:0]    value;
    logic [deq_pkg::POS_W-1:0]            position;

    modport source (output valid, output action, output value, output position,
                    input ready);
    modport sink   (input valid, input action, input value, input position,
                    output ready);

endinterface

`default_nettype wire

@@ hdl/deq_out_if.sv @@
// ----------------------------------------------------------------------------
// deq_out_if
// Response channel: one result per command transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_out_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [deq_pkg::DATA_W-1:0]    read_data;
    logic [deq_pkg::STATUS_W-1:0]         status;
    logic signed [deq_pkg::DATA_W-1:0]    front_value;
    logic signed [deq_pkg::DATA_W-1:0]    back_value;
    logic [deq_pkg::OCC_W-1:0]            occupancy;
    logic                                 is_empty;

    modport source (output valid, output read_data, output status,
                    output front_value, output back_value, output occupancy,
                    output is_empty, input ready);
    modport sink   (input valid, input read_data, input status,
                    input front_value, input back_value, input occupancy,
                    input is_empty, output ready);

endinterface

`default_nettype wire

@@ hdl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Ring pointer, count, cached end words and response register; drives the
// slot RAM and waits one cycle where a slot has to be read.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    deq_in_if.sink                      cmd,
    deq_out_if.source                   rsp,
    output deq_pkg::ram_req_t           ram_req,
    input  wire logic [deq_pkg::DATA_W-1:0] ram_rdata
);

    import deq_pkg::*;

    localparam int WIDE_W = CNT_W + POS_W;
    localparam logic [CNT_W:0] CAP_EXT = (CNT_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    typedef enum logic {S_IDLE, S_WAIT} state_t;
    typedef enum logic [1:0] {P_READ, P_POP_FRONT, P_POP_BACK} pend_t;

    state_t              state_reg, state_next;
    pend_t               pend_reg, pend_next;
    logic [IDX_W-1:0]    front_idx_reg, front_idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DATA_W-1:0]   front_word_reg, front_word_next;
    logic [DATA_W-1:0]   back_word_reg, back_word_next;

    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [DATA_W-1:0]   out_front_reg, out_front_next;
    logic [DATA_W-1:0]   out_back_reg, out_back_next;
    logic [OCC_W-1:0]    out_occ_reg, out_occ_next;
    logic                out_empty_reg, out_empty_next;

    logic                out_free;
    logic                accept;
    logic                load;
    logic [DATA_W-1:0]   res_data;
    status_t             res_status;
    logic [WIDE_W-1:0]   pos_wide;
    logic [WIDE_W-1:0]   cnt_wide;
    logic [CNT_W+OCC_W-1:0] occ_wide;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + {1'b0, off};
        if (sum >= CAP_EXT)
        begin
            sum = sum - CAP_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        state_next      = state_reg;
        pend_next       = pend_reg;
        front_idx_next  = front_idx_reg;
        count_next      = count_reg;
        front_word_next = front_word_reg;
        back_word_next  = back_word_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        out_occ_next    = out_occ_reg;
        out_empty_next  = out_empty_reg;
        ram_req         = '0;
        load            = 1'b0;
        res_data        = '0;
        res_status      = ST_OK;
        pos_wide        = WIDE_W'(cmd.position);
        cnt_wide        = WIDE_W'(count_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    case (action_t'(cmd.action))
                        ACT_PUSH_BACK:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = ring_add(front_idx_reg, count_reg);
                                ram_req.wdata = cmd.value;
                                count_next    = count_reg + 1'b1;
                                back_word_next = cmd.value;
                                if (count_reg == '0)
                                begin
                                    front_word_next = cmd.value;
                                end
                            end
                        end
                        ACT_PUSH_FRONT:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                front_idx_next = (front_idx_reg == '0) ? LAST_IDX
                                                                       : front_idx_reg - 1'b1;
                                ram_req.we      = 1'b1;
                                ram_req.waddr   = front_idx_next;
                                ram_req.wdata   = cmd.value;
                                count_next      = count_reg + 1'b1;
                                front_word_next = cmd.value;
                                if (count_reg == '0)
                                begin
                                    back_word_next = cmd.value;
                                end
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                if (count_next != '0)
                                begin
                                    ram_req.re    = 1'b1;
                                    ram_req.raddr = ring_add(front_idx_reg,
                                                             count_next - 1'b1);
                                    pend_next     = P_POP_BACK;
                                    state_next    = S_WAIT;
                                    load          = 1'b0;
                                end
                            end
                        end
                        ACT_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next     = count_reg - 1'b1;
                                front_idx_next = ring_add(front_idx_reg, CNT_W'(1));
                                if (count_next != '0)
                                begin
                                    ram_req.re    = 1'b1;
                                    ram_req.raddr = front_idx_next;
                                    pend_next     = P_POP_FRONT;
                                    state_next    = S_WAIT;
                                    load          = 1'b0;
                                end
                            end
                        end
                        ACT_READ:
                        begin
                            if (pos_wide >= cnt_wide)
                            begin
                                res_status = ST_RANGE;
                                res_data   = '1;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = ring_add(front_idx_reg,
                                                         pos_wide[CNT_W-1:0]);
                                pend_next     = P_READ;
                                state_next    = S_WAIT;
                                load          = 1'b0;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next     = '0;
                            front_idx_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    unique case (pend_reg)
                        P_READ:      res_data        = ram_rdata;
                        P_POP_FRONT: front_word_next = ram_rdata;
                        P_POP_BACK:  back_word_next  = ram_rdata;
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        occ_wide = (CNT_W + OCC_W)'(count_next);
        if (load)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = res_data;
            out_status_next = res_status;
            out_occ_next    = occ_wide[OCC_W-1:0];
            out_empty_next  = (count_next == '0);
            out_front_next  = out_empty_next ? '0 : front_word_next;
            out_back_next   = out_empty_next ? '0 : back_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_reg       <= P_READ;
            front_idx_reg  <= '0;
            count_reg      <= '0;
            front_word_reg <= '0;
            back_word_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_status_reg <= '0;
            out_front_reg  <= '0;
            out_back_reg   <= '0;
            out_occ_reg    <= '0;
            out_empty_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            front_idx_reg  <= front_idx_next;
            count_reg      <= count_next;
            front_word_reg <= front_word_next;
            back_word_reg  <= back_word_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            out_front_reg  <= out_front_next;
            out_back_reg   <= out_back_next;
            out_occ_reg    <= out_occ_next;
            out_empty_reg  <= out_empty_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.front_value = out_front_reg;
    assign rsp.back_value  = out_back_reg;
    assign rsp.occupancy   = out_occ_reg;
    assign rsp.is_empty    = out_empty_reg;

endmodule

`default_nettype wire

@@ hdl/double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of 32-bit words held in a ring of slot RAM.
// ----------------------------------------------------------------------------
// Pushes, clear, out-of-range reads, pops on an empty queue and pops that leave
// the queue empty are answered from the idle state; in-range reads and pops
// that leave elements pass through a wait state, held until the response
// register is free, for the registered read of the slot RAM that fetches the
// word or the new end word. The front and back words are cached in registers.
// A command is taken once the previous command has its response made and that
// response is out of the way; the response register holds the result until it
// is taken. Slot contents are not cleared by reset or by the clear action.
`default_nettype none

`include "double_ended_queue_top_assert.svh"

module double_ended_queue_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_in_if.sink     cmd,
    deq_out_if.source  rsp
);

    import deq_pkg::*;

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    `DEQ_ASSERT_IMP(a_empty_ends_zero, rsp.valid && rsp.is_empty, rsp.front_value == '0 && rsp.back_value == '0, "empty queue reports non-zero end word")
    `DEQ_ASSERT_IMP(a_range_minus_one, rsp.valid && rsp.status == ST_RANGE, rsp.read_data == '1, "out-of-range read without all-ones data")
    `DEQ_ASSERT_IMP(a_full_occupancy, rsp.valid && rsp.status == ST_FULL, rsp.occupancy == OCC_W'(CAPACITY), "full status below capacity")
    `DEQ_ASSERT_NXT(a_clear_empties, cmd.valid && cmd.ready && cmd.action == ACT_CLEAR, rsp.valid && rsp.is_empty, "clear not answered with an empty queue")

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended queue. Queue actions are sent over
// the command channel while a behavioural copy of the ring predicts each
// response. Responses are compared field by field as they arrive. A short
// directed run covers the empty queue, both ends and the extreme words, clear
// and pointer wrap. Random traffic then fills the ring to full and drains it
// to empty, with mixed traffic in between, under three back-pressure profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import deq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        status_t                  status;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
    } deq_result_t;

    typedef enum {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    deq_in_if  cmd_if ();
    deq_out_if rsp_if ();

    double_ended_queue_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // behavioural copy of the ring
    logic signed [DATA_W-1:0] ring_mem [CAPACITY];
    int                       head_idx;
    int                       fill_count;

    deq_result_t   pending_results [$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            tx_idle_pct = 20;
    int            rx_idle_pct = 86;
    traffic_mode_t traffic_mode = MODE_MIXED;
    int            mode_steps = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d responses outstanding", $time,
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic deq_result_t next_deque_result(input logic [ACTION_W-1:0] act,
                                                      input logic signed [DATA_W-1:0] val,
                                                      input logic [POS_W-1:0] pos);
        deq_result_t r;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_PUSH_BACK:
                if (fill_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    ring_mem[(head_idx + fill_count) % CAPACITY] = val;
                    fill_count++;
                end
            ACT_PUSH_FRONT:
                if (fill_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    head_idx = (head_idx + CAPACITY - 1) % CAPACITY;
                    ring_mem[head_idx] = val;
                    fill_count++;
                end
            ACT_POP_BACK:
                if (fill_count == 0)
                    r.status = ST_EMPTY;
                else
                    fill_count--;
            ACT_POP_FRONT:
                if (fill_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    head_idx = (head_idx + 1) % CAPACITY;
                    fill_count--;
                end
            ACT_READ:
                if (int'(pos) >= fill_count)
                begin
                    r.status = ST_RANGE;
                    r.read_data = -1;
                end
                else
                    r.read_data = ring_mem[(head_idx + int'(pos)) % CAPACITY];
            ACT_CLEAR:
            begin
                fill_count = 0;
                head_idx = 0;
            end
            default:
                ;
        endcase
        if (fill_count != 0)
        begin
            r.front_value = ring_mem[head_idx];
            r.back_value = ring_mem[(head_idx + fill_count - 1) % CAPACITY];
        end
        r.occupancy = OCC_W'(fill_count);
        r.is_empty = (fill_count == 0);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t %s: expected %h, actual %h", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : response_check
        deq_result_t golden;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t response with none outstanding: expected none, actual %h",
                         $time, rsp_if.read_data);
                error_count++;
            end
            else
            begin
                golden = pending_results.pop_front();
                check_field("read_data", golden.read_data, rsp_if.read_data);
                check_field("status", golden.status, rsp_if.status);
                check_field("front_value", golden.front_value, rsp_if.front_value);
                check_field("back_value", golden.back_value, rsp_if.back_value);
                check_field("occupancy", golden.occupancy, rsp_if.occupancy);
                check_field("is_empty", golden.is_empty, rsp_if.is_empty);
            end
        end
    end

    // valid stays high after the transfer until the next send or hold_cmd
    task automatic send_cmd(input logic [ACTION_W-1:0] act,
                            input logic signed [DATA_W-1:0] val,
                            input logic [POS_W-1:0] pos);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.action <= act;
        cmd_if.value <= val;
        cmd_if.position <= pos;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        pending_results.push_back(next_deque_result(act, val, pos));
    endtask

    task automatic hold_cmd();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        hold_cmd();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (traffic_mode)
            MODE_FILL:
                if (roll < 44)      return ACT_PUSH_BACK;
                else if (roll < 88) return ACT_PUSH_FRONT;
                else if (roll < 91) return ACT_POP_BACK;
                else if (roll < 94) return ACT_POP_FRONT;
                else                return ACT_READ;
            MODE_DRAIN:
                if (roll < 43)      return ACT_POP_BACK;
                else if (roll < 86) return ACT_POP_FRONT;
                else if (roll < 90) return ACT_PUSH_BACK;
                else if (roll < 93) return ACT_PUSH_FRONT;
                else                return ACT_READ;
            default:
                if (roll < 20)      return ACT_PUSH_BACK;
                else if (roll < 40) return ACT_PUSH_FRONT;
                else if (roll < 55) return ACT_POP_BACK;
                else if (roll < 70) return ACT_POP_FRONT;
                else if (roll < 95) return ACT_READ;
                else                return ACT_CLEAR;
        endcase
    endfunction

    task automatic test_empty_queue();
        send_cmd(ACT_READ, 32'sd0, 8'd0);
        send_cmd(ACT_READ, 32'sd0, 8'd255);
        send_cmd(ACT_POP_BACK, 32'sd0, 8'd0);
        send_cmd(ACT_POP_FRONT, 32'sd0, 8'd0);
    endtask

    task automatic test_push_pop_ends();
        send_cmd(ACT_PUSH_BACK, 32'sh7fffffff, 8'd0);
        send_cmd(ACT_PUSH_BACK, 32'sh80000000, 8'd255);
        send_cmd(ACT_PUSH_FRONT, -32'sd1, 8'd0);
        send_cmd(ACT_PUSH_FRONT, 32'sd0, 8'd0);
        send_cmd(ACT_READ, 32'sd0, 8'd0);
        send_cmd(ACT_READ, 32'sd0, 8'd1);
        send_cmd(ACT_READ, 32'sd0, 8'd2);
        send_cmd(ACT_READ, 32'sd0, 8'd3);
        send_cmd(ACT_READ, 32'sd0, 8'd4);
        send_cmd(ACT_POP_FRONT, 32'sd0, 8'd0);
        send_cmd(ACT_POP_BACK, 32'sd0, 8'd0);
        send_cmd(ACT_READ, 32'sd0, 8'd0);
    endtask

    task automatic test_clear_and_wrap();
        send_cmd(ACT_CLEAR, 32'sd0, 8'd0);
        send_cmd(ACT_READ, 32'sd0, 8'd0);
        send_cmd(ACT_PUSH_FRONT, 32'sh12345678, 8'd0);
        send_cmd(ACT_PUSH_BACK, 32'sh55aa55aa, 8'd0);
        send_cmd(ACT_POP_BACK, 32'sd0, 8'd0);
        send_cmd(ACT_POP_FRONT, 32'sd0, 8'd0);
        send_cmd(ACT_CLEAR, 32'sd0, 8'd0);
    endtask

    // fill to full, drain to empty, mixed traffic with clears, and round again
    task automatic test_random(input int num_items);
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        for (int i = 0; i < num_items; i++)
        begin
            if (i == num_items / 2)
                wait_for_results();
            act = pick_action();
            if (act == ACT_READ && fill_count != 0 && $urandom_range(0, 1))
                pos = POS_W'($urandom_range(0, fill_count - 1));
            else
                pos = POS_W'($urandom_range(0, 255));
            send_cmd(act, pick_value(), pos);
            if (traffic_mode == MODE_MIXED
                || fill_count == (traffic_mode == MODE_FILL ? CAPACITY : 0))
                mode_steps++;
            if (mode_steps >= (traffic_mode == MODE_MIXED ? 50 : 12))
            begin
                mode_steps = 0;
                case (traffic_mode)
                    MODE_FILL:  traffic_mode = MODE_DRAIN;
                    MODE_DRAIN: traffic_mode = MODE_MIXED;
                    default:    traffic_mode = MODE_FILL;
                endcase
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        cmd_if.valid = 1'b0;
        cmd_if.action = ACT_PUSH_BACK;
        cmd_if.value = '0;
        cmd_if.position = '0;
        rst_n = 1'b0;
        head_idx = 0;
        fill_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 20;
        rx_idle_pct = 86;
        test_empty_queue();
        test_push_pop_ends();
        test_clear_and_wrap();
        wait_for_results();
        test_random(370);

        tx_idle_pct = 86;
        rx_idle_pct = 20;
        test_random(370);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(370);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
